@@ hw/rtl/bpc_pkg.sv @@
// Package for the button press classifier: sizes, item codes and the
// command/status structs between controller and datapath. No dependencies.
package bpc_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int BTN_W       = 2;
    localparam int STAMP_W     = 32;
    localparam int CODE_W      = 2;
    localparam int KIND_W      = 2;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 40;

    localparam logic [KIND_W-1:0] KIND_EDGE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POLL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    localparam logic [CODE_W-1:0] EV_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] EV_SHORT = 2'd1;
    localparam logic [CODE_W-1:0] EV_LONG  = 2'd2;

    localparam logic RK_POLL = 1'b0;
    localparam logic RK_READ = 1'b1;

    localparam logic REG_LONG_PRESS = 1'b0;
    localparam logic REG_DEBOUNCE   = 1'b1;

    typedef struct packed {
        logic             load;
        logic             edge_upd;
        logic             read_upd;
        logic             emit;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic seen_cur;
        logic slot_free;
    } t_sts;

endpackage

@@ hw/rtl/button_press_classifier_core.sv @@
// Top level of the button press classifier: joins controller and datapath.
// Depends on bpc_pkg, bpc_ctrl and bpc_datapath.
//
// Usage: items enter on the s_axis channel; tuser carries the item kind
// (edge, poll, read). Results leave on m_axis; tuser carries the result
// kind and tlast marks the final result of a poll or the single read answer.
// Registers are written on the cfg channel, which is always ready; write
// them only while the block is idle.
// An edge item is accepted and then updates the button state. A read item
// is accepted and then answered once the output register is free. A poll
// steps through the buttons in order with the scan counter, holding on a
// button with a result pending while the output register is occupied.
// One output register holds a finished result; a new item is accepted while
// it waits. When the receiver stalls the scan holds on the released button
// until the register drains. Reset clears all button state, pending events,
// the output valid flag and restores long_press_ms 500 and debounce_ms 20.
module button_press_classifier_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] button_id, [2] level_pressed, [34:3] now_ms, [39:35] zero
    input  logic [bpc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [1:0] kind
    input  logic [bpc_pkg::KIND_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] button_out, [3:2] event_code, [35:4] duration_ms, [39:36] zero
    output logic [bpc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // [0] result_kind
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [bpc_pkg::STAMP_W-1:0]         i_cfg_data
);

    bpc_pkg::t_cmd w_cmd;
    bpc_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    bpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_kind  (s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    bpc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

@@ hw/rtl/bpc_ctrl.sv @@
// Controller state machine of the button press classifier: dispatches items
// and walks the buttons for a poll. Depends on bpc_pkg.
module bpc_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [bpc_pkg::KIND_W-1:0]     i_kind,
    output logic                           o_ready,
    input  bpc_pkg::t_sts                  i_sts,
    output bpc_pkg::t_cmd                  o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EDGE = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_SCAN = 2'd3;

    localparam logic [bpc_pkg::IDX_W-1:0] IDX_END =
        bpc_pkg::IDX_W'(bpc_pkg::NUM_BUTTONS - 1);

    logic [1:0]                r_state, n_state;
    logic [bpc_pkg::IDX_W-1:0] r_idx, n_idx;
    logic                      w_accept;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_cmd        = '0;
        o_cmd.idx    = r_idx;
        o_cmd.load   = w_accept;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_idx = '0;
                    case (i_kind)
                        bpc_pkg::KIND_EDGE: n_state = ST_EDGE;
                        bpc_pkg::KIND_POLL: n_state = ST_SCAN;
                        bpc_pkg::KIND_READ: n_state = ST_READ;
                        default:            n_state = ST_IDLE;
                    endcase
                end
            end
            ST_EDGE: begin
                o_cmd.edge_upd = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_READ: begin
                if (i_sts.slot_free) begin
                    o_cmd.read_upd = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!i_sts.seen_cur || i_sts.slot_free) begin
                    o_cmd.emit = i_sts.seen_cur;
                    if (r_idx == IDX_END) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

@@ hw/rtl/bpc_datapath.sv @@
// Datapath of the button press classifier: per-button state, configuration
// registers, debounce and classify arithmetic, output register. Uses bpc_pkg.
module bpc_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [bpc_pkg::IN_DATA_W-1:0]      i_in_data,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [bpc_pkg::STAMP_W-1:0]        i_cfg_data,
    input  bpc_pkg::t_cmd                      i_cmd,
    output bpc_pkg::t_sts                      o_sts,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [bpc_pkg::OUT_DATA_W-1:0]     o_out_data,
    output logic                               o_out_kind,
    output logic                               o_out_last
);

    localparam int NB = bpc_pkg::NUM_BUTTONS;
    localparam int SW = bpc_pkg::STAMP_W;

    logic [SW-1:0]                 r_long_ms, r_deb_ms;
    logic [bpc_pkg::BTN_W-1:0]     r_id;
    logic                          r_level;
    logic [SW-1:0]                 r_now;

    logic [NB-1:0]                 r_is_down, r_seen;
    logic [SW-1:0]                 r_press  [NB];
    logic [SW-1:0]                 r_release[NB];
    logic [SW-1:0]                 r_last_edge[NB];
    logic [bpc_pkg::CODE_W-1:0]    r_pending[NB];

    logic                          r_out_valid, r_out_kind, r_out_last;
    logic [bpc_pkg::BTN_W-1:0]     r_out_btn;
    logic [bpc_pkg::CODE_W-1:0]    r_out_code;
    logic [SW-1:0]                 r_out_dur;

    logic                          w_in_range;
    logic [bpc_pkg::IDX_W-1:0]     w_id_idx;
    logic [SW-1:0]                 w_since;
    logic                          w_bounce;
    logic [SW-1:0]                 w_dur;
    logic [bpc_pkg::CODE_W-1:0]    w_code;
    logic                          w_more;

    assign w_in_range = ({1'b0, r_id} < (bpc_pkg::BTN_W + 1)'(NB));
    assign w_id_idx   = bpc_pkg::IDX_W'(r_id);
    assign w_since    = r_now - r_last_edge[w_id_idx];
    assign w_bounce   = (w_since < r_deb_ms);
    assign w_dur      = r_release[i_cmd.idx] - r_press[i_cmd.idx];
    assign w_code     = (w_dur >= r_long_ms) ? bpc_pkg::EV_LONG : bpc_pkg::EV_SHORT;

    always_comb begin
        w_more = 1'b0;
        for (int j = 0; j < NB; j++) begin
            if ((bpc_pkg::IDX_W'(j) > i_cmd.idx) && r_seen[j]) begin
                w_more = 1'b1;
            end
        end
    end

    assign o_sts.seen_cur  = r_seen[i_cmd.idx];
    assign o_sts.slot_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;
    assign o_out_data  = {4'b0, r_out_dur, r_out_code, r_out_btn};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ms   <= SW'(500);
            r_deb_ms    <= SW'(20);
            r_is_down   <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < NB; j++) begin
                r_press[j]     <= '0;
                r_release[j]   <= '0;
                r_last_edge[j] <= '0;
                r_pending[j]   <= bpc_pkg::EV_NONE;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bpc_pkg::REG_LONG_PRESS: r_long_ms <= i_cfg_data;
                    bpc_pkg::REG_DEBOUNCE:   r_deb_ms  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_id    <= i_in_data[1:0];
                r_level <= i_in_data[2];
                r_now   <= i_in_data[34:3];
            end
            if (i_cmd.read_upd || i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.edge_upd && w_in_range && !w_bounce) begin
                r_last_edge[w_id_idx] <= r_now;
                if (r_level) begin
                    r_is_down[w_id_idx] <= 1'b1;
                    r_press[w_id_idx]   <= r_now;
                end else if (r_is_down[w_id_idx]) begin
                    r_seen[w_id_idx]    <= 1'b1;
                    r_release[w_id_idx] <= r_now;
                end
            end
            if (i_cmd.read_upd) begin
                r_out_kind  <= bpc_pkg::RK_READ;
                r_out_btn   <= r_id;
                r_out_dur   <= '0;
                r_out_last  <= 1'b1;
                if (w_in_range) begin
                    r_out_code          <= r_pending[w_id_idx];
                    r_pending[w_id_idx] <= bpc_pkg::EV_NONE;
                end else begin
                    r_out_code <= bpc_pkg::EV_NONE;
                end
            end
            if (i_cmd.emit) begin
                r_seen[i_cmd.idx]    <= 1'b0;
                r_is_down[i_cmd.idx] <= 1'b0;
                r_pending[i_cmd.idx] <= w_code;
                r_out_kind           <= bpc_pkg::RK_POLL;
                r_out_btn            <= bpc_pkg::BTN_W'(i_cmd.idx);
                r_out_code           <= w_code;
                r_out_dur            <= w_dur;
                r_out_last           <= !w_more;
            end
        end
    end

endmodule
